FILE: hdl/iqpc_pkg.sv
// Shared constants, register indexes and the CORDIC arctangent table for the
// IQ imbalance polar converter. No dependencies.

package iqpc_pkg;

  localparam int GAIN_W      = 16;
  localparam int PHASE_W     = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int ANGLE_GUARD = 8;
  localparam int ZW          = 25;
  localparam int ATAN_LEN    = 24;
  localparam int PHASE_LIMIT = 23040;

  localparam logic [CFG_IDX_W-1:0] REG_REAL_GAIN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAG_GAIN = CFG_IDX_W'(1);

  localparam logic signed [GAIN_W-1:0] REAL_GAIN_RST = GAIN_W'(16384);
  localparam logic signed [GAIN_W-1:0] IMAG_GAIN_RST = GAIN_W'(0);

  localparam logic signed [ZW-1:0] HALF_TURN = ZW'(5898240);

  // atan(2^-k) in units of 1/32768 degree, rounded to nearest.
  function automatic logic signed [ZW-1:0] atan_val(input int unsigned idx);
    logic signed [ZW-1:0] v;
    unique case (idx)
      0:       v = ZW'(1474560);
      1:       v = ZW'(870484);
      2:       v = ZW'(459940);
      3:       v = ZW'(233473);
      4:       v = ZW'(117189);
      5:       v = ZW'(58652);
      6:       v = ZW'(29333);
      7:       v = ZW'(14667);
      8:       v = ZW'(7334);
      9:       v = ZW'(3667);
      10:      v = ZW'(1833);
      11:      v = ZW'(917);
      12:      v = ZW'(458);
      13:      v = ZW'(229);
      14:      v = ZW'(115);
      15:      v = ZW'(57);
      16:      v = ZW'(29);
      17:      v = ZW'(14);
      18:      v = ZW'(7);
      19:      v = ZW'(4);
      20:      v = ZW'(2);
      21:      v = ZW'(1);
      default: v = ZW'(0);
    endcase
    return v;
  endfunction

endpackage

FILE: hdl/iq_imbalance_polar_converter.sv
// Top level of the IQ imbalance polar converter: imbalance multiply, square
// root and CORDIC vectoring pipelines. Depends on iqpc_pkg.

// One I/Q word is taken in every clock cycle; busy is held low. Each result
// word leaves after the imbalance stages and the longer of two paths: the
// square root, which resolves one bit per stage, and the CORDIC chain of
// one stage per iteration. The result is shown for exactly one cycle with
// out_valid high; the receiver cannot stall the block, so it must take
// every word.
module iq_imbalance_polar_converter #(
  parameter int SAMPLE_WIDTH  = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic        [iqpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [iqpc_pkg::GAIN_W-1:0]     cfg_data,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [SAMPLE_WIDTH-1:0]         in_i,
  input  logic signed [SAMPLE_WIDTH-1:0]         in_q,
  output logic                                   out_valid,
  output logic signed [SAMPLE_WIDTH-1:0]         out_i,
  output logic signed [SAMPLE_WIDTH-1:0]         out_q,
  output logic        [SAMPLE_WIDTH-1:0]         out_magnitude,
  output logic signed [iqpc_pkg::PHASE_W-1:0]    out_phase_deg
);

  import iqpc_pkg::*;

  localparam int W       = SAMPLE_WIDTH;
  localparam int PW      = W + GAIN_W;
  localparam int SW      = W + 18;
  localparam int XW      = W + ANGLE_GUARD + 2;
  localparam int RW      = W + 2;
  localparam int N_EFF   = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;
  localparam int MAG_LAT = W + 3;
  localparam int PH_LAT  = N_EFF + 2;
  localparam int ALIGN   = (MAG_LAT > PH_LAT) ? MAG_LAT : PH_LAT;
  localparam int MAG_PAD = ALIGN - MAG_LAT;
  localparam int PH_PAD  = ALIGN - PH_LAT;
  localparam int TOT     = ALIGN + 2;
  localparam int PZW     = ZW - 7;

  localparam logic signed [W+3:0]  SAT_HI = {{5{1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [W+3:0]  SAT_LO = {{5{1'b1}}, {(W-1){1'b0}}};
  localparam logic        [SW-1:0] RND14  = {{(W+4){1'b0}}, 14'h2000};
  localparam logic signed [ZW:0]   RND8   = (ZW+1)'(128);
  localparam logic signed [PZW-1:0] PH_HI = PZW'(PHASE_LIMIT);
  localparam logic signed [PZW-1:0] PH_LO = -PZW'(PHASE_LIMIT);

  logic signed [GAIN_W-1:0] real_gain_r;
  logic signed [GAIN_W-1:0] imag_gain_r;

  logic [TOT-1:0] vld_r;

  logic signed [W-1:0]  si_r;
  logic signed [PW-1:0] prod_i_r;
  logic signed [PW-1:0] prod_q_r;

  logic        [SW-1:0] sum_i;
  logic        [SW-1:0] sum_q;
  logic signed [W+3:0]  sh_i;
  logic signed [W+3:0]  sh_q;
  logic signed [W-1:0]  oi_nxt;
  logic signed [W-1:0]  oq_nxt;
  logic signed [W-1:0]  oi_r;
  logic signed [W-1:0]  oq_r;

  logic [W-1:0]   abs_i;
  logic [W-1:0]   abs_q;
  logic [2*W-1:0] sqi_r;
  logic [2*W-1:0] sqq_r;
  logic [2*W-1:0] sum2_r;

  logic [RW-1:0]  rt_rem_in   [0:W-1];
  logic [W-1:0]   rt_root_in  [0:W-1];
  logic [2*W-1:0] rt_s_in     [0:W-1];
  logic [W+3:0]   rt_rsh      [0:W-1];
  logic [W+3:0]   rt_trial    [0:W-1];
  logic [RW-1:0]  rt_rem_nxt  [1:W];
  logic [W-1:0]   rt_root_nxt [1:W];
  logic [RW-1:0]  rt_rem_r    [1:W];
  logic [W-1:0]   rt_root_r   [1:W];
  logic [2*W-1:0] rt_s_r      [1:W-1];
  logic [W-1:0]   mag_nxt;
  logic [W-1:0]   mag_r;

  logic signed [XW-1:0] x0_nxt;
  logic signed [XW-1:0] y0_nxt;
  logic signed [ZW-1:0] z0_nxt;
  logic signed [XW-1:0] cx_r     [0:N_EFF-1];
  logic signed [XW-1:0] cy_r     [0:N_EFF-1];
  logic signed [ZW-1:0] cz_r     [0:N_EFF];
  logic                 czero_r  [0:N_EFF];
  logic signed [XW-1:0] cx_nxt   [1:N_EFF-1];
  logic signed [XW-1:0] cy_nxt   [1:N_EFF-1];
  logic signed [ZW-1:0] cz_nxt   [1:N_EFF];
  logic signed [ZW:0]   pz;
  logic signed [PZW-1:0] pz_sh;
  logic signed [PHASE_W-1:0] ph_nxt;
  logic signed [PHASE_W-1:0] ph_r;

  logic signed [W-1:0] oi_dly_r [1:ALIGN];
  logic signed [W-1:0] oq_dly_r [1:ALIGN];
  logic [W-1:0]              mag_out;
  logic signed [PHASE_W-1:0] ph_out;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      real_gain_r <= REAL_GAIN_RST;
      imag_gain_r <= IMAG_GAIN_RST;
      vld_r       <= '0;
    end else begin
      vld_r <= {vld_r[TOT-2:0], start};
      if (cfg_we) begin
        if (cfg_index == REG_REAL_GAIN) begin
          real_gain_r <= cfg_data;
        end else if (cfg_index == REG_IMAG_GAIN) begin
          imag_gain_r <= cfg_data;
        end
      end
    end
  end

  // Imbalance products, then rounding and saturation.
  always_ff @(posedge clk) begin
    si_r     <= in_i;
    prod_i_r <= imag_gain_r * in_q;
    prod_q_r <= real_gain_r * in_q;
  end

  always_comb begin
    sum_i = {{4{si_r[W-1]}}, si_r, 14'b0} - {{2{prod_i_r[PW-1]}}, prod_i_r} + RND14;
    sum_q = {{2{prod_q_r[PW-1]}}, prod_q_r} + RND14;
    sh_i  = sum_i[SW-1:14];
    sh_q  = sum_q[SW-1:14];
    if (sh_i > SAT_HI) begin
      oi_nxt = SAT_HI[W-1:0];
    end else if (sh_i < SAT_LO) begin
      oi_nxt = SAT_LO[W-1:0];
    end else begin
      oi_nxt = sh_i[W-1:0];
    end
    if (sh_q > SAT_HI) begin
      oq_nxt = SAT_HI[W-1:0];
    end else if (sh_q < SAT_LO) begin
      oq_nxt = SAT_LO[W-1:0];
    end else begin
      oq_nxt = sh_q[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    oi_r <= oi_nxt;
    oq_r <= oq_nxt;
  end

  // Magnitude: squares, sum, then a restoring square root one bit per stage.
  assign abs_i = oi_r[W-1] ? W'(-oi_r) : oi_r;
  assign abs_q = oq_r[W-1] ? W'(-oq_r) : oq_r;

  always_ff @(posedge clk) begin
    sqi_r  <= abs_i * abs_i;
    sqq_r  <= abs_q * abs_q;
    sum2_r <= sqi_r + sqq_r;
  end

  always_comb begin
    rt_rem_in[0]  = '0;
    rt_root_in[0] = '0;
    rt_s_in[0]    = sum2_r;
    for (int g = 1; g < W; g++) begin
      rt_rem_in[g]  = rt_rem_r[g];
      rt_root_in[g] = rt_root_r[g];
      rt_s_in[g]    = rt_s_r[g];
    end
    for (int g = 0; g < W; g++) begin
      rt_rsh[g]   = {rt_rem_in[g], rt_s_in[g][2*W-1:2*W-2]};
      rt_trial[g] = {2'b00, rt_root_in[g], 2'b01};
      if (rt_rsh[g] >= rt_trial[g]) begin
        rt_rem_nxt[g+1]  = RW'(rt_rsh[g] - rt_trial[g]);
        rt_root_nxt[g+1] = {rt_root_in[g][W-2:0], 1'b1};
      end else begin
        rt_rem_nxt[g+1]  = rt_rsh[g][RW-1:0];
        rt_root_nxt[g+1] = {rt_root_in[g][W-2:0], 1'b0};
      end
    end
    if ((rt_rem_r[W] > {2'b00, rt_root_r[W]}) && !(&rt_root_r[W])) begin
      mag_nxt = rt_root_r[W] + 1'b1;
    end else begin
      mag_nxt = rt_root_r[W];
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 1; g <= W; g++) begin
      rt_rem_r[g]  <= rt_rem_nxt[g];
      rt_root_r[g] <= rt_root_nxt[g];
    end
    for (int g = 1; g < W; g++) begin
      rt_s_r[g] <= {rt_s_in[g-1][2*W-3:0], 2'b00};
    end
    mag_r <= mag_nxt;
  end

  // Phase: fold into the right half plane, then CORDIC vectoring.
  always_comb begin
    x0_nxt = {{2{oi_r[W-1]}}, oi_r, {ANGLE_GUARD{1'b0}}};
    y0_nxt = {{2{oq_r[W-1]}}, oq_r, {ANGLE_GUARD{1'b0}}};
    z0_nxt = '0;
    if (oi_r[W-1]) begin
      z0_nxt = oq_r[W-1] ? -HALF_TURN : HALF_TURN;
      x0_nxt = -x0_nxt;
      y0_nxt = -y0_nxt;
    end
  end

  always_comb begin
    for (int k = 0; k < N_EFF - 1; k++) begin
      if (!cy_r[k][XW-1]) begin
        cx_nxt[k+1] = cx_r[k] + (cy_r[k] >>> k);
        cy_nxt[k+1] = cy_r[k] - (cx_r[k] >>> k);
      end else begin
        cx_nxt[k+1] = cx_r[k] - (cy_r[k] >>> k);
        cy_nxt[k+1] = cy_r[k] + (cx_r[k] >>> k);
      end
    end
    for (int k = 0; k < N_EFF; k++) begin
      if (!cy_r[k][XW-1]) begin
        cz_nxt[k+1] = cz_r[k] + atan_val(k);
      end else begin
        cz_nxt[k+1] = cz_r[k] - atan_val(k);
      end
    end
  end

  always_comb begin
    pz    = {cz_r[N_EFF][ZW-1], cz_r[N_EFF]} + RND8;
    pz_sh = pz[ZW:8];
    if (czero_r[N_EFF]) begin
      ph_nxt = '0;
    end else if (pz_sh > PH_HI) begin
      ph_nxt = PH_HI[PHASE_W-1:0];
    end else if (pz_sh < PH_LO) begin
      ph_nxt = PH_LO[PHASE_W-1:0];
    end else begin
      ph_nxt = pz_sh[PHASE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    cx_r[0]    <= x0_nxt;
    cy_r[0]    <= y0_nxt;
    cz_r[0]    <= z0_nxt;
    czero_r[0] <= (oi_r == '0) && (oq_r == '0);
    for (int k = 1; k < N_EFF; k++) begin
      cx_r[k] <= cx_nxt[k];
      cy_r[k] <= cy_nxt[k];
    end
    for (int k = 1; k <= N_EFF; k++) begin
      cz_r[k]    <= cz_nxt[k];
      czero_r[k] <= czero_r[k-1];
    end
    ph_r <= ph_nxt;
  end

  // Alignment of the four result fields.
  always_ff @(posedge clk) begin
    oi_dly_r[1] <= oi_r;
    oq_dly_r[1] <= oq_r;
    for (int d = 2; d <= ALIGN; d++) begin
      oi_dly_r[d] <= oi_dly_r[d-1];
      oq_dly_r[d] <= oq_dly_r[d-1];
    end
  end

  generate
    if (MAG_PAD == 0) begin : g_mag_nopad
      assign mag_out = mag_r;
    end else begin : g_mag_pad
      logic [W-1:0] mag_dly_r [1:MAG_PAD];
      always_ff @(posedge clk) begin
        mag_dly_r[1] <= mag_r;
        for (int d = 2; d <= MAG_PAD; d++) begin
          mag_dly_r[d] <= mag_dly_r[d-1];
        end
      end
      assign mag_out = mag_dly_r[MAG_PAD];
    end
    if (PH_PAD == 0) begin : g_ph_nopad
      assign ph_out = ph_r;
    end else begin : g_ph_pad
      logic signed [PHASE_W-1:0] ph_dly_r [1:PH_PAD];
      always_ff @(posedge clk) begin
        ph_dly_r[1] <= ph_r;
        for (int d = 2; d <= PH_PAD; d++) begin
          ph_dly_r[d] <= ph_dly_r[d-1];
        end
      end
      assign ph_out = ph_dly_r[PH_PAD];
    end
  endgenerate

  assign out_valid     = vld_r[TOT-1];
  assign out_i         = oi_dly_r[ALIGN];
  assign out_q         = oq_dly_r[ALIGN];
  assign out_magnitude = mag_out;
  assign out_phase_deg = ph_out;

endmodule

FILE: bench/iq_imbalance_polar_converter_tb.sv
// Self-checking testbench for iq_imbalance_polar_converter: directed and random I/Q
// words under several gain settings, checked against a bit-exact predictor.
// Depends on iqpc_pkg and the converter RTL.
`timescale 1ns / 1ps

module iq_imbalance_polar_converter_tb;
  import iqpc_pkg::*;

  localparam int SAMPLE_W     = 16;
  localparam int STAGES       = 16;
  localparam int SETTLE       = 30;
  localparam int LIMIT_CYCLES = 200000;
  localparam int WORDS_PER_PH = 215;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

  localparam int ATAN_UNITS [0:23] = '{
    1474560, 870484, 459940, 233473, 117189, 58652, 29333, 14667,
    7334, 3667, 1833, 917, 458, 229, 115, 57,
    29, 14, 7, 4, 2, 1, 0, 0
  };

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] samp_i;
    logic signed [SAMPLE_W-1:0] samp_q;
    logic        [SAMPLE_W-1:0] mag;
    logic signed [PHASE_W-1:0]  phase;
  } polar_word_t;

  class iq_polar_scoreboard;
    logic signed [GAIN_W-1:0] real_gain = REAL_GAIN_RST;
    logic signed [GAIN_W-1:0] imag_gain = IMAG_GAIN_RST;
    polar_word_t pending_words[$];
    int words_in  = 0;
    int words_out = 0;
    int errors    = 0;

    function automatic longint clamp_sample(longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    function automatic polar_word_t predict_polar(logic signed [SAMPLE_W-1:0] si,
                                                  logic signed [SAMPLE_W-1:0] sq);
      longint oi, oq, x, y, z, dx, dy, p;
      longint unsigned s, r, b, n;
      int stages;
      polar_word_t w;
      oi = clamp_sample((longint'(si) * 16384 - longint'(imag_gain) * longint'(sq) + 8192)
                        >>> 14);
      oq = clamp_sample((longint'(real_gain) * longint'(sq) + 8192) >>> 14);
      s = longint'(oi * oi + oq * oq);
      r = 0;
      n = s;
      b = 64'h4000_0000_0000_0000;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      if (s - r * r > r) r = r + 1;
      if (r > (64'd1 << SAMPLE_W) - 1) r = (64'd1 << SAMPLE_W) - 1;
      p = 0;
      if (oi != 0 || oq != 0) begin
        x = oi * (longint'(1) <<< ANGLE_GUARD);
        y = oq * (longint'(1) <<< ANGLE_GUARD);
        z = 0;
        if (x < 0) begin
          z = (y >= 0) ? longint'(HALF_TURN) : -longint'(HALF_TURN);
          x = -x;
          y = -y;
        end
        stages = (STAGES > ATAN_LEN) ? ATAN_LEN : STAGES;
        for (int k = 0; k < stages; k++) begin
          dx = y >>> k;
          dy = x >>> k;
          if (y >= 0) begin
            x = x + dx;
            y = y - dy;
            z = z + ATAN_UNITS[k];
          end else begin
            x = x - dx;
            y = y + dy;
            z = z - ATAN_UNITS[k];
          end
        end
        p = (z + 128) >>> 8;
        if (p > PHASE_LIMIT) p = PHASE_LIMIT;
        if (p < -PHASE_LIMIT) p = -PHASE_LIMIT;
      end
      w.samp_i = oi[SAMPLE_W-1:0];
      w.samp_q = oq[SAMPLE_W-1:0];
      w.mag    = r[SAMPLE_W-1:0];
      w.phase  = p[PHASE_W-1:0];
      return w;
    endfunction

    function void note_word(logic signed [SAMPLE_W-1:0] si, logic signed [SAMPLE_W-1:0] sq);
      pending_words.push_back(predict_polar(si, sq));
      words_in++;
    endfunction

    function void check_word(polar_word_t got);
      polar_word_t want;
      words_out++;
      if (pending_words.size() == 0) begin
        $error("Result word arrived with no input word outstanding.");
        errors++;
        return;
      end
      want = pending_words.pop_front();
      if (got.samp_i !== want.samp_i) begin
        $error("out_i: expected %0d, got %0d", want.samp_i, got.samp_i);
        errors++;
      end
      if (got.samp_q !== want.samp_q) begin
        $error("out_q: expected %0d, got %0d", want.samp_q, got.samp_q);
        errors++;
      end
      if (got.mag !== want.mag) begin
        $error("out_magnitude: expected %0d, got %0d", want.mag, got.mag);
        errors++;
      end
      if (got.phase !== want.phase) begin
        $error("out_phase_deg: expected %0d, got %0d", want.phase, got.phase);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [GAIN_W-1:0] cfg_data = '0;
  logic start = 1'b0;
  logic busy;
  logic signed [SAMPLE_W-1:0] in_i = '0;
  logic signed [SAMPLE_W-1:0] in_q = '0;
  logic out_valid;
  logic signed [SAMPLE_W-1:0] out_i;
  logic signed [SAMPLE_W-1:0] out_q;
  logic [SAMPLE_W-1:0] out_magnitude;
  logic signed [PHASE_W-1:0] out_phase_deg;

  iq_imbalance_polar_converter #(
    .SAMPLE_WIDTH (SAMPLE_W),
    .CORDIC_STAGES(STAGES)
  ) uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .start        (start),
    .busy         (busy),
    .in_i         (in_i),
    .in_q         (in_q),
    .out_valid    (out_valid),
    .out_i        (out_i),
    .out_q        (out_q),
    .out_magnitude(out_magnitude),
    .out_phase_deg(out_phase_deg)
  );

  iq_polar_scoreboard sb = new();
  int cycles = 0;
  int gain_settings = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && start && !busy) sb.note_word(in_i, in_q);
    if (rst_n && out_valid) sb.check_word({out_i, out_q, out_magnitude, out_phase_deg});
  end

  task automatic configure(input logic signed [GAIN_W-1:0] rg,
                           input logic signed [GAIN_W-1:0] ig, input bit touch_spare);
    cfg_we    <= 1'b1;
    cfg_index <= REG_REAL_GAIN;
    cfg_data  <= rg;
    @(posedge clk);
    sb.real_gain = rg;
    cfg_index <= REG_IMAG_GAIN;
    cfg_data  <= ig;
    @(posedge clk);
    sb.imag_gain = ig;
    if (touch_spare) begin
      cfg_index <= ($urandom_range(1) != 0) ? REG_SPARE_A : REG_SPARE_B;
      cfg_data  <= GAIN_W'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    gain_settings++;
  endtask

  task automatic send_word(input logic signed [SAMPLE_W-1:0] si,
                           input logic signed [SAMPLE_W-1:0] sq, input int idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start <= 1'b1;
    in_i  <= si;
    in_q  <= sq;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    logic signed [SAMPLE_W-1:0] v;
    case ($urandom_range(9))
      0: v = 16'sh7fff;
      1: v = 16'sh8000;
      2: v = '0;
      3, 4: v = SAMPLE_W'($urandom_range(511)) - SAMPLE_W'(256);
      default: v = SAMPLE_W'($urandom);
    endcase
    return v;
  endfunction

  logic signed [SAMPLE_W-1:0] dir_i [0:23] = '{
    16'sh7fff, 16'sh8000, 0, 16'sh8000, -1, 0, 0, 1, 16'sh7fff, 16'sh8000, -1, 4096,
    16'sh7fff, 16'sh8000, 0, 0, 1, 16'sh7fff, 16'sh8000, 0, 100, -5, 16384, 16'sh8000
  };
  logic signed [SAMPLE_W-1:0] dir_q [0:23] = '{
    16'sh7fff, 16'sh8000, 0, 0, -1, 16'sh7fff, 16'sh8000, 0, 16'sh8000, 16'sh7fff, 0, -4096,
    16'sh8000, 16'sh7fff, 1, -1, 1, 16'sh7fff, 16'sh8000, 0, -100, 3, 16384, 1
  };

  initial begin
    logic signed [GAIN_W-1:0] rg;
    logic signed [GAIN_W-1:0] ig;
    int idle_pct;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int n = 0; n < 24; n++) begin
      if (n == 12) begin
        drain();
        configure(16'sh8000, 16'sh7fff, 1'b0);
      end
      send_word(dir_i[n], dir_q[n], 0);
    end
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin rg = REAL_GAIN_RST; ig = IMAG_GAIN_RST; idle_pct = 0; end
        1: begin rg = 16'sh7fff; ig = 16'sh8000; idle_pct = 47; end
        2: begin rg = '0; ig = '0; idle_pct = 0; end
        3: begin
          rg = GAIN_W'(16384 + $urandom_range(2000) - 1000);
          ig = GAIN_W'($urandom_range(1600) - 800);
          idle_pct = 28;
        end
        default: begin
          rg = GAIN_W'($urandom);
          ig = GAIN_W'($urandom);
          idle_pct = (ph == 4) ? 47 : 28;
        end
      endcase
      configure(rg, ig, 1'b1);
      for (int n = 0; n < WORDS_PER_PH; n++) begin
        if (ph == 1 && n == WORDS_PER_PH / 2) drain();
        send_word(pick_sample(), pick_sample(), (n % 60 < 15) ? 0 : idle_pct);
      end
      drain();
    end

    $display("Run sent %0d I/Q words and checked %0d results over %0d gain settings,",
             sb.words_in, sb.words_out, gain_settings + 1);
    $display("covering full-scale, saturating, zero and random vectors with sender gaps.");
    if (sb.errors == 0 && sb.pending_words.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
